### design/pwt_pkg.sv
// Shared types, constants and helpers for the prediction weight table parser.
// Depends on nothing; every other file of the block imports it.
package pwt_pkg;

  localparam int MAX_REFS          = 32;
  localparam int MAX_LEADING_ZEROS = 31;
  localparam int REF_W             = 5;
  localparam int ZC_W              = 6;
  localparam int CODE_W            = 32;
  localparam int VALUE_W           = 33;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 5;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = 1;
  localparam int QCNT_W            = 2;

  localparam logic [REF_W-1:0] REF_LIMIT = REF_W'(MAX_REFS - 1);
  localparam logic [ZC_W-1:0]  ZC_LIMIT  = ZC_W'(MAX_LEADING_ZEROS);

  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_B_SLICE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFS_L0       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFS_L1       = 2'd3;

  typedef enum logic [2:0] {
    PH_LUMA_DENOM    = 3'd0,
    PH_CHROMA_DENOM  = 3'd1,
    PH_LUMA_FLAG     = 3'd2,
    PH_LUMA_WEIGHT   = 3'd3,
    PH_LUMA_OFFSET   = 3'd4,
    PH_CHROMA_FLAG   = 3'd5,
    PH_CHROMA_WEIGHT = 3'd6,
    PH_CHROMA_OFFSET = 3'd7
  } phase_t;

  typedef struct packed {
    phase_t            kind;
    logic              list_sel;
    logic [REF_W-1:0]  ref_index;
    logic              chroma_comp;
    logic [CODE_W-1:0] code;
    logic              table_done;
    logic              code_error;
  } elem_t;

  function automatic logic is_signed_kind(input phase_t kind);
    return (kind == PH_LUMA_WEIGHT) || (kind == PH_LUMA_OFFSET) ||
           (kind == PH_CHROMA_WEIGHT) || (kind == PH_CHROMA_OFFSET);
  endfunction

endpackage

### design/pwt_front.sv
// Front end: configuration registers, Exp-Golomb bit decoder and syntax sequencer.
// Pushes one raw element record per finished code or over-long prefix. Depends on pwt_pkg.
module pwt_front import pwt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  bit_in,
  output logic                  push,
  input  logic                  push_ready,
  output elem_t                 push_data
);

  logic [1:0]       chroma_format_kind;
  logic             is_b_slice;
  logic [REF_W-1:0] refs_list0_minus1;
  logic [REF_W-1:0] refs_list1_minus1;

  phase_t           phase, phase_next;
  logic             cur_list, cur_list_next;
  logic [REF_W-1:0] ref_cnt, ref_cnt_next;
  logic             comp_cnt, comp_cnt_next;
  logic             in_suffix, in_suffix_next;
  logic [ZC_W-1:0]  zero_count, zero_count_next;
  logic [ZC_W-1:0]  suffix_left, suffix_left_next;
  logic [CODE_W-1:0] code_accum, code_accum_next;

  logic              fire;
  logic              emit;
  logic              err;
  logic [CODE_W-1:0] code;
  logic              table_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign fire      = in_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_format_kind <= 2'd1;
      is_b_slice         <= 1'b0;
      refs_list0_minus1  <= '0;
      refs_list1_minus1  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHROMA_FORMAT: chroma_format_kind <= cfg_data[1:0];
        CFG_IS_B_SLICE:    is_b_slice         <= cfg_data[0];
        CFG_REFS_L0:       refs_list0_minus1  <= cfg_data[REF_W-1:0];
        CFG_REFS_L1:       refs_list1_minus1  <= cfg_data[REF_W-1:0];
        default: ;
      endcase
    end
  end

  // Exp-Golomb decode of the current bit
  always_comb begin
    logic [CODE_W-1:0]  shifted;
    logic [ZC_W-1:0]    sl_dec;
    logic [VALUE_W-1:0] full;
    shifted          = {code_accum[CODE_W-2:0], bit_in};
    sl_dec           = (suffix_left != '0) ? suffix_left - 1'b1 : '0;
    full             = (VALUE_W'(1) << zero_count) - VALUE_W'(1) + VALUE_W'(shifted);
    emit             = 1'b0;
    err              = 1'b0;
    code             = '0;
    in_suffix_next   = in_suffix;
    zero_count_next  = zero_count;
    suffix_left_next = suffix_left;
    code_accum_next  = code_accum;
    if (fire) begin
      if (phase == PH_LUMA_FLAG || phase == PH_CHROMA_FLAG) begin
        emit = 1'b1;
        code = CODE_W'(bit_in);
      end else if (!in_suffix) begin
        if (!bit_in) begin
          if (zero_count >= ZC_LIMIT) begin
            emit            = 1'b1;
            err             = 1'b1;
            zero_count_next = '0;
            code_accum_next = '0;
          end else begin
            zero_count_next = zero_count + 1'b1;
          end
        end else if (zero_count != '0) begin
          in_suffix_next   = 1'b1;
          suffix_left_next = zero_count;
          code_accum_next  = '0;
        end else begin
          emit             = 1'b1;
          suffix_left_next = '0;
          code_accum_next  = '0;
        end
      end else begin
        code_accum_next  = shifted;
        suffix_left_next = sl_dec;
        if (sl_dec == '0) begin
          emit            = 1'b1;
          code            = full[CODE_W-1:0];
          in_suffix_next  = 1'b0;
          zero_count_next = '0;
          code_accum_next = '0;
        end
      end
    end
  end

  // Next position in the table
  always_comb begin
    logic             go_next_ref;
    logic [REF_W-1:0] limit;
    phase_next    = phase;
    cur_list_next = cur_list;
    ref_cnt_next  = ref_cnt;
    comp_cnt_next = comp_cnt;
    table_end     = 1'b0;
    go_next_ref   = 1'b0;
    limit         = cur_list ? refs_list1_minus1 : refs_list0_minus1;
    if (limit > REF_LIMIT) begin
      limit = REF_LIMIT;
    end
    if (emit && err) begin
      phase_next    = PH_LUMA_DENOM;
      cur_list_next = 1'b0;
      ref_cnt_next  = '0;
      comp_cnt_next = 1'b0;
    end else if (emit) begin
      case (phase)
        PH_LUMA_DENOM: begin
          phase_next = (chroma_format_kind != 2'd0) ? PH_CHROMA_DENOM : PH_LUMA_FLAG;
        end
        PH_CHROMA_DENOM: phase_next = PH_LUMA_FLAG;
        PH_LUMA_FLAG: begin
          if (code[0]) begin
            phase_next = PH_LUMA_WEIGHT;
          end else if (chroma_format_kind != 2'd0) begin
            phase_next = PH_CHROMA_FLAG;
          end else begin
            go_next_ref = 1'b1;
          end
        end
        PH_LUMA_WEIGHT: phase_next = PH_LUMA_OFFSET;
        PH_LUMA_OFFSET: begin
          if (chroma_format_kind != 2'd0) begin
            phase_next = PH_CHROMA_FLAG;
          end else begin
            go_next_ref = 1'b1;
          end
        end
        PH_CHROMA_FLAG: begin
          if (code[0]) begin
            comp_cnt_next = 1'b0;
            phase_next    = PH_CHROMA_WEIGHT;
          end else begin
            go_next_ref = 1'b1;
          end
        end
        PH_CHROMA_WEIGHT: phase_next = PH_CHROMA_OFFSET;
        PH_CHROMA_OFFSET: begin
          if (!comp_cnt) begin
            comp_cnt_next = 1'b1;
            phase_next    = PH_CHROMA_WEIGHT;
          end else begin
            comp_cnt_next = 1'b0;
            go_next_ref   = 1'b1;
          end
        end
        default: phase_next = PH_LUMA_DENOM;
      endcase
      if (go_next_ref) begin
        if (ref_cnt < limit) begin
          ref_cnt_next = ref_cnt + 1'b1;
          phase_next   = PH_LUMA_FLAG;
        end else if (!cur_list && is_b_slice) begin
          cur_list_next = 1'b1;
          ref_cnt_next  = '0;
          phase_next    = PH_LUMA_FLAG;
        end else begin
          phase_next    = PH_LUMA_DENOM;
          cur_list_next = 1'b0;
          ref_cnt_next  = '0;
          comp_cnt_next = 1'b0;
          table_end     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push                  = emit;
    push_data.kind        = phase;
    push_data.list_sel    = cur_list;
    push_data.ref_index   = ref_cnt;
    push_data.chroma_comp = comp_cnt;
    push_data.code        = code;
    push_data.table_done  = table_end;
    push_data.code_error  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LUMA_DENOM;
      cur_list    <= 1'b0;
      ref_cnt     <= '0;
      comp_cnt    <= 1'b0;
      in_suffix   <= 1'b0;
      zero_count  <= '0;
      suffix_left <= '0;
      code_accum  <= '0;
    end else begin
      phase       <= phase_next;
      cur_list    <= cur_list_next;
      ref_cnt     <= ref_cnt_next;
      comp_cnt    <= comp_cnt_next;
      in_suffix   <= in_suffix_next;
      zero_count  <= zero_count_next;
      suffix_left <= suffix_left_next;
      code_accum  <= code_accum_next;
    end
  end

endmodule

### design/pwt_fifo.sv
// Two-entry element queue between the front end and the output stage.
// Depends on pwt_pkg for the element record.
module pwt_fifo import pwt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  push_ready,
  input  elem_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output elem_t pop_data
);

  elem_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/pwt_back.sv
// Output stage: maps signed Exp-Golomb codes and holds the result register.
// Depends on pwt_pkg for the element record and kind codes.
module pwt_back import pwt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  output logic                      pop,
  input  elem_t                     pop_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                element_kind,
  output logic                      list_sel,
  output logic [REF_W-1:0]          ref_index,
  output logic                      chroma_comp,
  output logic signed [VALUE_W-1:0] elem_value,
  output logic                      table_done,
  output logic                      code_error
);

  logic [VALUE_W-1:0] ext;
  logic [VALUE_W-1:0] mapped;

  assign pop = pop_valid && (!out_valid || out_ready);
  assign ext = VALUE_W'(pop_data.code);

  always_comb begin
    if (!is_signed_kind(pop_data.kind)) begin
      mapped = ext;
    end else if (pop_data.code[0]) begin
      mapped = (ext + VALUE_W'(1)) >> 1;
    end else begin
      mapped = VALUE_W'(0) - (ext >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      element_kind <= pop_data.kind;
      list_sel     <= pop_data.list_sel;
      ref_index    <= pop_data.ref_index;
      chroma_comp  <= pop_data.chroma_comp;
      elem_value   <= mapped;
      table_done   <= pop_data.table_done;
      code_error   <= pop_data.code_error;
    end
  end

endmodule

### design/pred_weight_table_parser_top.sv
// Prediction weight table parser, top level: front end, element queue, output stage.
// Depends on pwt_pkg, pwt_front, pwt_fifo and pwt_back.
//
// Takes the slice-header bitstream one bit per transaction and returns one
// transaction per syntax element of the weight table. The front end takes a bit
// every clock cycle as long as its two-entry element queue has room; the output
// register drains the queue at one element per cycle while out_ready is high, so
// with out_ready held high the sustained rate is one bit per cycle. A finished code
// is written into the queue and then moved into the output register. Configuration
// writes are always taken and should be issued only while the block is idle.
module pred_weight_table_parser_top import pwt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      bit_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                element_kind,
  output logic                      list_sel,
  output logic [REF_W-1:0]          ref_index,
  output logic                      chroma_comp,
  output logic signed [VALUE_W-1:0] elem_value,
  output logic                      table_done,
  output logic                      code_error
);

  logic  push;
  logic  push_ready;
  elem_t push_data;
  logic  pop_valid;
  logic  pop;
  elem_t pop_data;

  pwt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .bit_in     (bit_in),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pwt_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  pwt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .element_kind (element_kind),
    .list_sel     (list_sel),
    .ref_index    (ref_index),
    .chroma_comp  (chroma_comp),
    .elem_value   (elem_value),
    .table_done   (table_done),
    .code_error   (code_error)
  );

endmodule

### sim/tb_pred_weight_table_parser_top.sv
`timescale 1ns / 1ps
// Testbench for pred_weight_table_parser_top: bit-serial stimulus, element scoreboard.
// Depends on pwt_pkg and the parser RTL; needs no files or arguments at run time.

import pwt_pkg::*;

typedef struct packed {
  phase_t             kind;
  logic               lst;
  logic [REF_W-1:0]   ref_idx;
  logic               comp;
  logic [VALUE_W-1:0] value;
  logic               done;
  logic               err;
} weight_elem_t;

class weight_table_scoreboard;
  logic [1:0]        chroma_kind;
  logic              b_slice;
  logic [REF_W-1:0]  refs0_m1;
  logic [REF_W-1:0]  refs1_m1;
  phase_t            phase;
  logic              lst;
  logic [REF_W-1:0]  ref_cnt;
  logic              comp;
  logic              in_suffix;
  logic [ZC_W-1:0]   zeros;
  logic [ZC_W-1:0]   suffix_left;
  logic [CODE_W-1:0] accum;
  weight_elem_t      expected_elems[$];
  int                errors;
  int                checked;
  int                tables;
  int                prefix_errors;
  logic [7:0]        kinds_seen;

  function new();
    chroma_kind   = 2'd1;
    b_slice       = 1'b0;
    refs0_m1      = '0;
    refs1_m1      = '0;
    errors        = 0;
    checked       = 0;
    tables        = 0;
    prefix_errors = 0;
    kinds_seen    = '0;
    restart_table();
    clear_code();
  endfunction

  function void restart_table();
    phase   = PH_LUMA_DENOM;
    lst     = 1'b0;
    ref_cnt = '0;
    comp    = 1'b0;
  endfunction

  function void clear_code();
    in_suffix   = 1'b0;
    zeros       = '0;
    suffix_left = '0;
    accum       = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CHROMA_FORMAT: chroma_kind = data[1:0];
      CFG_IS_B_SLICE:    b_slice = data[0];
      CFG_REFS_L0:       refs0_m1 = data;
      CFG_REFS_L1:       refs1_m1 = data;
      default: ;
    endcase
  endfunction

  function bit next_ref();
    logic [REF_W-1:0] lim;
    lim = lst ? refs1_m1 : refs0_m1;
    if (ref_cnt < lim) begin
      ref_cnt++;
      phase = PH_LUMA_FLAG;
      return 1'b0;
    end
    if (!lst && b_slice) begin
      lst = 1'b1;
      ref_cnt = '0;
      phase = PH_LUMA_FLAG;
      return 1'b0;
    end
    restart_table();
    return 1'b1;
  endfunction

  function bit after_luma();
    if (chroma_kind != 0) begin
      phase = PH_CHROMA_FLAG;
      return 1'b0;
    end
    return next_ref();
  endfunction

  function bit advance_phase(logic flag);
    case (phase)
      PH_LUMA_DENOM: begin
        phase = (chroma_kind != 0) ? PH_CHROMA_DENOM : PH_LUMA_FLAG;
        return 1'b0;
      end
      PH_CHROMA_DENOM: begin
        phase = PH_LUMA_FLAG;
        return 1'b0;
      end
      PH_LUMA_FLAG: begin
        if (flag) begin
          phase = PH_LUMA_WEIGHT;
          return 1'b0;
        end
        return after_luma();
      end
      PH_LUMA_WEIGHT: begin
        phase = PH_LUMA_OFFSET;
        return 1'b0;
      end
      PH_LUMA_OFFSET: return after_luma();
      PH_CHROMA_FLAG: begin
        if (flag) begin
          comp = 1'b0;
          phase = PH_CHROMA_WEIGHT;
          return 1'b0;
        end
        return next_ref();
      end
      PH_CHROMA_WEIGHT: begin
        phase = PH_CHROMA_OFFSET;
        return 1'b0;
      end
      default: begin
        if (!comp) begin
          comp = 1'b1;
          phase = PH_CHROMA_WEIGHT;
          return 1'b0;
        end
        comp = 1'b0;
        return next_ref();
      end
    endcase
  endfunction

  function void note_bit(logic b);
    logic [VALUE_W-1:0] code;
    logic [VALUE_W-1:0] half;
    weight_elem_t       e;
    if (phase == PH_LUMA_FLAG || phase == PH_CHROMA_FLAG) begin
      code = {{(VALUE_W-1){1'b0}}, b};
    end else if (!in_suffix) begin
      if (!b) begin
        if (zeros >= MAX_LEADING_ZEROS) begin
          e.kind    = phase;
          e.lst     = lst;
          e.ref_idx = ref_cnt;
          e.comp    = comp;
          e.value   = '0;
          e.done    = 1'b0;
          e.err     = 1'b1;
          expected_elems.insert(expected_elems.size(), e);
          restart_table();
          clear_code();
          return;
        end
        zeros++;
        return;
      end
      if (zeros != 0) begin
        in_suffix   = 1'b1;
        suffix_left = zeros;
        accum       = '0;
        return;
      end
      code = '0;
      clear_code();
    end else begin
      accum = {accum[CODE_W-2:0], b};
      if (suffix_left > 0) suffix_left--;
      if (suffix_left != 0) return;
      code = (VALUE_W'(1) << zeros) - VALUE_W'(1) + {1'b0, accum};
      clear_code();
    end
    e.kind    = phase;
    e.lst     = lst;
    e.ref_idx = ref_cnt;
    e.comp    = comp;
    e.err     = 1'b0;
    half      = code >> 1;
    if (phase == PH_LUMA_WEIGHT || phase == PH_LUMA_OFFSET ||
        phase == PH_CHROMA_WEIGHT || phase == PH_CHROMA_OFFSET)
      e.value = code[0] ? half + 1'b1 : -half;
    else
      e.value = code;
    e.done = advance_phase(code[0]);
    expected_elems.insert(expected_elems.size(), e);
  endfunction

  function void check_element(weight_elem_t got);
    weight_elem_t       want;
    logic [VALUE_W-1:0] want_f[7];
    logic [VALUE_W-1:0] got_f[7];
    string              names[7];
    if (expected_elems.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none, actual kind %0d value %0h",
               $time, got.kind, got.value);
      return;
    end
    want   = expected_elems.pop_front();
    names  = '{"element_kind", "list_sel", "ref_index", "chroma_comp",
               "elem_value", "table_done", "code_error"};
    want_f = '{VALUE_W'(want.kind), VALUE_W'(want.lst), VALUE_W'(want.ref_idx),
               VALUE_W'(want.comp), want.value, VALUE_W'(want.done), VALUE_W'(want.err)};
    got_f  = '{VALUE_W'(got.kind), VALUE_W'(got.lst), VALUE_W'(got.ref_idx),
               VALUE_W'(got.comp), got.value, VALUE_W'(got.done), VALUE_W'(got.err)};
    foreach (names[i]) begin
      if (want_f[i] !== got_f[i]) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, names[i],
                 want_f[i], got_f[i]);
      end
    end
    checked++;
    kinds_seen[want.kind] = 1'b1;
    if (want.done) tables++;
    if (want.err) prefix_errors++;
  endfunction
endclass

module tb_pred_weight_table_parser_top;
  localparam int LIMIT_CYCLES = 600000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      bit_in;
  logic                      out_valid;
  logic                      out_ready;
  logic [2:0]                element_kind;
  logic                      list_sel;
  logic [REF_W-1:0]          ref_index;
  logic                      chroma_comp;
  logic signed [VALUE_W-1:0] elem_value;
  logic                      table_done;
  logic                      code_error;

  weight_table_scoreboard sb;
  weight_elem_t           observed;
  int                     cycles;
  int                     bits_sent;
  bit                     idle_on;
  bit                     stall_on;

  pred_weight_table_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .bit_in       (bit_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .element_kind (element_kind),
    .list_sel     (list_sel),
    .ref_index    (ref_index),
    .chroma_comp  (chroma_comp),
    .elem_value   (elem_value),
    .table_done   (table_done),
    .code_error   (code_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d elements pending", $time, sb.expected_elems.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed.kind    = phase_t'(element_kind);
      observed.lst     = list_sel;
      observed.ref_idx = ref_index;
      observed.comp    = chroma_comp;
      observed.value   = elem_value;
      observed.done    = table_done;
      observed.err     = code_error;
      sb.check_element(observed);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_bit(input logic b);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    bit_in   <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_bit(b);
    bits_sent++;
  endtask

  task automatic send_code(input int n, input logic [CODE_W-1:0] suffix);
    repeat (n) send_bit(1'b0);
    send_bit(1'b1);
    for (int i = n - 1; i >= 0; i--) send_bit(suffix[i]);
  endtask

  // hold the bit stream until every element is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_elems.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int c, input int b, input int r0, input int r1);
    logic [CFG_DATA_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0]  idxs[4];
    idxs = '{CFG_CHROMA_FORMAT, CFG_IS_B_SLICE, CFG_REFS_L0, CFG_REFS_L1};
    vals = '{CFG_DATA_W'(c), CFG_DATA_W'(b), CFG_DATA_W'(r0), CFG_DATA_W'(r1)};
    foreach (idxs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int nbits, input int flag_pct, input int long_pct);
    int target;
    int r;
    target = bits_sent + nbits;
    while (bits_sent < target) begin
      if (sb.phase == PH_LUMA_FLAG || sb.phase == PH_CHROMA_FLAG) begin
        send_bit($urandom_range(0, 99) < flag_pct);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3)
          repeat (MAX_LEADING_ZEROS + 1) send_bit(1'b0);
        else if (r < 8)
          repeat ($urandom_range(1, 5)) send_bit(1'($urandom_range(0, 1)));
        else if (r < 8 + long_pct)
          send_code($urandom_range(8, MAX_LEADING_ZEROS), $urandom());
        else
          send_code($urandom_range(0, 4), $urandom());
      end
    end
  endtask

  initial begin
    int setup[6][5];
    sb        = new();
    cycles    = 0;
    bits_sent = 0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    bit_in    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(1, 1, 0, 0);
    // full table of a two-list slice: every kind, both lists, both chroma components
    send_code(0, 0);
    send_code(0, 0);
    send_bit(1'b1);
    send_code(1, 0);
    send_code(1, 1);
    send_bit(1'b1);
    send_code(0, 0);
    send_code(1, 0);
    send_code(1, 1);
    send_code(2, 3);
    send_bit(1'b0);
    send_bit(1'b0);
    // longest codes, signed extremes, then an over-long prefix
    send_code(MAX_LEADING_ZEROS, '1);
    send_code(0, 0);
    send_bit(1'b1);
    send_code(MAX_LEADING_ZEROS, '1);
    send_code(MAX_LEADING_ZEROS, 32'h7FFF_FFFE);
    send_bit(1'b1);
    repeat (MAX_LEADING_ZEROS + 1) send_bit(1'b0);

    setup = '{'{0, 0, 31, 0, 40}, '{3, 1, 31, 31, 15}, '{1, 1, 2, 3, 70},
              '{2, 0, 0, 0, 80}, '{0, 1, 0, 0, 50}, '{1, 1, 1, 1, 60}};
    setup[4] = '{$urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 31),
                 $urandom_range(0, 31), 50};
    foreach (setup[p]) begin
      drain();
      if (p == 5) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      configure(setup[p][0], setup[p][1], setup[p][2], setup[p][3]);
      if (p == 2) begin
        run_random(80, setup[p][4], 10);
        drain();
        run_random(80, setup[p][4], 10);
      end else begin
        run_random(160, setup[p][4], 10);
      end
    end
    drain();

    $display("run: %0d bits in, %0d elements checked, %0d tables completed",
             bits_sent, sb.checked, sb.tables);
    $display("run: %0d over-long prefixes, element kinds seen mask %b",
             sb.prefix_errors, sb.kinds_seen);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t: %0d mismatches", $time, sb.errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
